FILE: src/length_prefixed_frame_receiver_core_assert.svh
// Assertion macros for the frame receiver checker.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LPFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lpfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  // Frame geometry
  localparam int BUFFER_BYTES = 64;
  localparam int LENGTH_POS   = 2;

  // Idle counter ceiling and timeout reset value
  localparam logic [8:0] IDLE_MAX      = 9'd511;
  localparam logic [8:0] TIMEOUT_RESET = 9'd256;

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_NOTHING  = 3'd4;

  // Input word
  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  // Result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] out_position;
    logic [2:0] status;
  } out_t;

  // Receiver state carried from word to word
  typedef struct packed {
    logic [7:0] byte_count;
    logic [7:0] frame_length;
    logic       timer_running;
    logic [8:0] idle_count;
  } lpfr_state_t;

endpackage

FILE: src/lpfr_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_update
// Next-state and result logic for one received byte or timer tick.
// ----------------------------------------------------------------------------
module lpfr_update import lpfr_pkg::*; (
  input  in_t         word,
  input  lpfr_state_t state,
  input  logic [8:0]  timeout_ticks,
  output lpfr_state_t state_next,
  output out_t        result
);

  logic [7:0] pos;
  logic [7:0] length_next;
  logic [8:0] taken;
  logic [8:0] frame_end;
  logic [8:0] limit;
  logic [8:0] idle_inc;

  // Frame position bookkeeping
  assign pos         = state.byte_count;
  assign length_next = (pos == 8'(LENGTH_POS)) ? word.rx_byte : state.frame_length;
  assign taken       = {1'b0, pos} + 9'd1;
  assign frame_end   = {1'b0, length_next} + 9'd4;

  // Idle timer: a zero limit acts as one, count saturates
  assign limit    = (timeout_ticks == 9'd0) ? 9'd1 : timeout_ticks;
  assign idle_inc = (state.idle_count != IDLE_MAX) ? state.idle_count + 9'd1
                                                   : state.idle_count;

  always_comb begin
    state_next = state;
    result     = '{out_byte: 8'd0, out_position: 8'd0, status: ST_NOTHING};
    case (word.req_type)
      REQ_BYTE: begin
        result.out_byte     = word.rx_byte;
        result.out_position = pos;
        if (pos >= 8'(BUFFER_BYTES)) begin
          // Drop the byte and abort on a full buffer
          state_next.byte_count    = 8'd0;
          state_next.timer_running = 1'b0;
          state_next.idle_count    = 9'd0;
          result.status            = ST_OVERFLOW;
        end else if (taken >= 9'd3 && taken >= frame_end) begin
          // Close the frame
          state_next.frame_length  = length_next;
          state_next.byte_count    = 8'd0;
          state_next.timer_running = 1'b0;
          state_next.idle_count    = 9'd0;
          result.status            = ST_COMPLETE;
        end else begin
          // Store and restart the idle timer
          state_next.frame_length  = length_next;
          state_next.byte_count    = taken[7:0];
          state_next.timer_running = 1'b1;
          state_next.idle_count    = 9'd0;
          result.status            = ST_STORED;
        end
      end
      REQ_TICK: begin
        if (state.timer_running) begin
          if (idle_inc >= limit) begin
            // Abort the open frame on timeout
            state_next.byte_count    = 8'd0;
            state_next.timer_running = 1'b0;
            state_next.idle_count    = 9'd0;
            result.out_position      = pos;
            result.status            = ST_TIMEOUT;
          end else begin
            state_next.idle_count = idle_inc;
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

FILE: src/length_prefixed_frame_receiver_core.sv
`timescale 1ns / 1ps
// Path from input accept to result valid: input register, then result register.
// Throughput: one word per cycle unless stalled; the frame state updates once per word.
// Backpressure on the result side stalls the input only when both registers are full.
// Reset (synchronous, active high): clears valids and frame state, timeout becomes 256.
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_core
// Length-prefixed frame receiver with inter-byte timeout, one result per word.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_core import lpfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data
);

  logic        in_reg_valid;
  in_t         in_reg;
  lpfr_state_t state;
  lpfr_state_t state_next;
  out_t        result;
  logic [8:0]  timeout_ticks;
  logic        advance;

  // Result register frees up when empty or drained this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_reg_valid || advance;

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg <= in_data;
    end
  end

  lpfr_update u_update (
    .word          (in_reg),
    .state         (state),
    .timeout_ticks (timeout_ticks),
    .state_next    (state_next),
    .result        (result)
  );

  // Advance frame state and result register together
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
      if (in_reg_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg_valid) begin
      out_data <= result;
    end
  end

endmodule

FILE: src/lpfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_receiver_core_assert.svh"

module lpfr_checker import lpfr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input out_t       out_data
);

  logic byte_status;
  logic status_known;
  logic stalled;
  logic tick_result;
  logic byte_zero;
  logic idle_result;
  logic pos_zero;
  logic stored_result;
  logic pos_in_buffer;

  // Status codes that carry a received byte
  assign byte_status = (out_data.status == ST_STORED) ||
                       (out_data.status == ST_COMPLETE) ||
                       (out_data.status == ST_OVERFLOW);
  assign status_known = byte_status || (out_data.status == ST_TIMEOUT) ||
                        (out_data.status == ST_NOTHING);

  assign stalled       = out_valid && !out_ready;
  assign tick_result   = out_valid && !byte_status;
  assign byte_zero     = (out_data.out_byte == 8'd0);
  assign idle_result   = out_valid && (out_data.status == ST_NOTHING);
  assign pos_zero      = (out_data.out_position == 8'd0);
  assign stored_result = out_valid &&
                         ((out_data.status == ST_STORED) || (out_data.status == ST_COMPLETE));
  assign pos_in_buffer = (out_data.out_position < 8'(BUFFER_BYTES));

  // A stalled result holds
  `LPFR_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "stall not held")

  // Only defined status codes leave the block
  `LPFR_ASSERT_NOW(a_status_legal, out_valid, status_known, "undefined status code")

  // Tick results carry no byte
  `LPFR_ASSERT_NOW(a_tick_byte_zero, tick_result, byte_zero, "tick result with nonzero byte")

  // Nothing to report means position zero
  `LPFR_ASSERT_NOW(a_nothing_pos, idle_result, pos_zero, "idle result with nonzero position")

  // Stored bytes stay inside the buffer
  `LPFR_ASSERT_NOW(a_pos_in_buffer, stored_result, pos_in_buffer, "stored byte beyond buffer")

endmodule

bind length_prefixed_frame_receiver_core lpfr_checker u_lpfr_checker (.*);

FILE: tb/sv/length_prefixed_frame_receiver_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_core_test
// Drives bytes and timer ticks into the frame receiver in bursts and checks
// every result word against an in-bench model of the frame state, across
// several timeout settings including the extremes of the register.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_core_test;
  import lpfr_pkg::*;

  localparam int WATCHDOG_CYCLES  = 2000;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES    = 6;
  localparam int LONG_CUT         = BUFFER_BYTES + 2;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  in_t        in_data   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [8:0] cfg_data  = '0;
  logic       in_ready;
  logic       out_valid;
  out_t       out_data;

  // Model of the frame state
  logic [7:0] held_count  = '0;
  logic [7:0] frame_len   = '0;
  logic       timer_on    = 1'b0;
  logic [8:0] idle_ticks  = '0;
  logic [8:0] timeout_now = TIMEOUT_RESET;

  in_t  send_words[$];
  out_t due_results[$];
  int   queued        = 0;
  int   fails         = 0;
  int   burst_left    = 0;
  int   gap_left      = 0;
  int   hold_left     = 0;
  bit   held_off_once = 1'b0;
  int   segment_left  = 0;
  bit   choppy        = 1'b0;
  int   stall_cycles  = 0;

  length_prefixed_frame_receiver_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective tick count that aborts an open frame
  function automatic int tick_limit();
    return (timeout_now == 0) ? 1 : int'(timeout_now);
  endfunction

  // Advance the frame state by one word and return the result it produces
  function automatic out_t receive_word(in_t w);
    out_t       r;
    int         taken;
    logic [8:0] limit;
    r = '0;
    if (w.req_type == REQ_BYTE) begin
      r.out_byte     = w.rx_byte;
      r.out_position = held_count;
      if (held_count >= BUFFER_BYTES) begin
        r.status   = ST_OVERFLOW;
        timer_on   = 1'b0;
        idle_ticks = '0;
        held_count = '0;
      end else begin
        if (held_count == LENGTH_POS) frame_len = w.rx_byte;
        taken      = int'(held_count) + 1;
        held_count = taken[7:0];
        idle_ticks = '0;
        if (taken >= 3 && taken >= int'(frame_len) + 4) begin
          r.status   = ST_COMPLETE;
          timer_on   = 1'b0;
          held_count = '0;
        end else begin
          r.status = ST_STORED;
          timer_on = 1'b1;
        end
      end
    end else if (!timer_on) begin
      r.status = ST_NOTHING;
    end else begin
      limit = (timeout_now == 0) ? 9'd1 : timeout_now;
      if (idle_ticks < IDLE_MAX) idle_ticks = idle_ticks + 9'd1;
      if (idle_ticks >= limit) begin
        r.out_position = held_count;
        r.status       = ST_TIMEOUT;
        timer_on       = 1'b0;
        idle_ticks     = '0;
        held_count     = '0;
      end else begin
        r.status = ST_NOTHING;
      end
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_t w;
    w.req_type = REQ_BYTE;
    w.rx_byte  = b;
    send_words.push_back(w);
    queued++;
  endtask

  // Ticks carry a random byte, which the block must ignore
  task automatic push_ticks(input int n);
    in_t w;
    for (int i = 0; i < n; i++) begin
      w.req_type = REQ_TICK;
      w.rx_byte  = 8'($urandom_range(0, 255));
      send_words.push_back(w);
      queued++;
    end
  endtask

  // Queue the first cut bytes of a frame of length len, with short idle runs
  task automatic push_frame(input int len, input int cut);
    int safe;
    safe = tick_limit() - 1;
    if (safe > 4) safe = 4;
    for (int i = 0; i < cut; i++) begin
      if (i > 0 && safe > 0 && $urandom_range(0, 3) == 0) push_ticks($urandom_range(1, safe));
      push_byte(i == LENGTH_POS ? len[7:0] : 8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly whole frames, some cut short by a timeout, some noise
  task automatic add_traffic(input int count);
    int stop_at;
    int sel;
    int len;
    int whole;
    stop_at = queued + count;
    while (queued < stop_at) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(56, 255) : $urandom_range(0, 6);
      // Stop long frames shortly after they overflow the buffer
      whole = (len + 4 > LONG_CUT) ? LONG_CUT : len + 4;
      if (sel < 70) begin
        push_frame(len, whole);
      end else if (sel < 85) begin
        push_frame(len, $urandom_range(1, whole - 1));
        push_ticks(tick_limit() <= 32 ? tick_limit() : $urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 1) push_byte(8'($urandom_range(0, 255)));
          else push_ticks(1);
        end
      end
    end
  endtask

  // Hold until every word is sent and every result is back, then settle
  task automatic wait_idle();
    while (send_words.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [8:0] v);
    wait_idle();
    cfg_we      <= 1'b1;
    cfg_data    <= v;
    timeout_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_results.push_back(receive_word(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_words.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= send_words.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: calm and choppy stretches, plus one long hold under load
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!held_off_once && send_words.size() > 80) begin
      hold_left     = LONG_HOLD_CYCLES;
      held_off_once = 1'b1;
      out_ready     <= 1'b0;
    end else begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(4, 40);
        choppy       = ($urandom_range(0, 1) == 1);
      end
      segment_left--;
      out_ready <= !choppy || ($urandom_range(0, 2) != 0);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result word %h with nothing expected", out_data);
        fails++;
      end else begin
        want = due_results.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0d, got %0d", want.out_byte, out_data.out_byte);
          fails++;
        end
        if (out_data.out_position !== want.out_position) begin
          $error("out_position: expected %0d, got %0d", want.out_position,
                 out_data.out_position);
          fails++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fails++;
        end
      end
    end
  end

  // Drop the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_CYCLES) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Tick with the timer stopped, shortest frames, extreme bytes
    push_ticks(1);
    push_byte(8'hFF); push_byte(8'h00); push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h01); push_byte(8'hAA); push_byte(8'h55);
    push_byte(8'h5A); push_byte(8'hA5); push_ticks(3);
    push_byte(8'h02); push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80);
    // Partial frame aborted at the reset timeout, then a stray tick
    push_byte(8'h01); push_byte(8'h02); push_ticks(256); push_ticks(1);

    // Timeout of zero acts as one
    set_timeout(9'd0);
    push_byte(8'h33); push_ticks(2);
    add_traffic(30);

    set_timeout(9'd1);
    add_traffic(30);

    // Frame that fills the buffer exactly, then one that overflows it
    set_timeout(9'd3);
    push_frame(60, 64);
    push_frame(61, 65);
    add_traffic(20);

    set_timeout(9'($urandom_range(2, 20)));
    add_traffic(30);

    // Largest timeout: a short idle run keeps the frame open
    set_timeout(IDLE_MAX);
    push_byte(8'h7E); push_ticks(8); push_byte(8'h81);

    set_timeout(TIMEOUT_RESET);
    add_traffic(20);

    wait_idle();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: length_prefixed_frame_receiver_core.f
+incdir+src
src/lpfr_pkg.sv
src/lpfr_update.sv
src/length_prefixed_frame_receiver_core.sv
src/lpfr_checker.sv
tb/sv/length_prefixed_frame_receiver_core_test.sv
